// ----- design/loop_port_group_table_top_defines.svh -----
// assertion macros shared by the loop group table rtl
`ifndef LOOP_PORT_GROUP_TABLE_TOP_DEFINES_SVH
`define LOOP_PORT_GROUP_TABLE_TOP_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define LPGT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define LPGT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lpgt_pkg.sv -----
// types and constants of the loop group table
package lpgt_pkg;

    // port and group id spaces, both indexed by a 4-bit field
    localparam int PORT_W     = 4;
    localparam int PORT_SLOTS = 16;
    localparam int GROUP_IDS  = 16;
    localparam int CNT_W      = 5;

    // operation codes of the func field
    localparam logic FUNC_LINK   = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // one port table entry
    typedef struct packed {
        logic              grouped;
        logic [PORT_W-1:0] grp;
    } port_ent_t;

    localparam int PORT_ENT_W = $bits(port_ent_t);

endpackage

// ----- design/loop_port_group_table_top.sv -----
// loop group table: top level with port table, member counts and sequencer
//
// Keeps switch ports in loop groups. One input beat (func, first_port,
// second_port) either links a receiving port to a sending port or removes
// a port from its group. Each input beat yields exactly one output beat
// (in_group, group_id, detect_request, detect_port) giving the group of
// first_port after the update and, when a group dissolved, its survivor.
// Both channels use valid/ready. The result is registered soonest when
// there is nothing to do (invalid port, same group) and latest for a new
// group on the last free id. The free id search walks the 16 member counts
// from id 0 up to the first zero, a merge walks ports 1 to 15 and a
// survivor search walks them up to the first member, one entry per cycle
// through the single read port of the member ram or the port ram. No new
// beat is taken before the last result is registered. in_ready is high
// while the sequencer is idle, also while the previous result still
// waits in the output register. If the receiver stalls with a result
// pending, the next item runs to its end and then holds until the output
// register frees up. Reset clears per-entry valid bits held in flip-flops,
// so every entry reads as zero right after reset.
module loop_port_group_table_top #(
    parameter int NUM_PORTS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       func,
    input  logic [lpgt_pkg::PORT_W-1:0] first_port,
    input  logic [lpgt_pkg::PORT_W-1:0] second_port,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       in_group,
    output logic [lpgt_pkg::PORT_W-1:0] group_id,
    output logic                       detect_request,
    output logic [lpgt_pkg::PORT_W-1:0] detect_port
);

`include "loop_port_group_table_top_defines.svh"

    localparam int PW = lpgt_pkg::PORT_W;
    localparam int CW = lpgt_pkg::CNT_W;
    localparam int EW = lpgt_pkg::PORT_ENT_W;
    localparam int IW = PW + 1;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDA   = 4'd1;
    localparam logic [3:0] S_RDB   = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_MERGE = 4'd4;
    localparam logic [3:0] S_FREE  = 4'd5;
    localparam logic [3:0] S_PW1   = 4'd6;
    localparam logic [3:0] S_PW2   = 4'd7;
    localparam logic [3:0] S_MRD   = 4'd8;
    localparam logic [3:0] S_MWR   = 4'd9;
    localparam logic [3:0] S_MCLR  = 4'd10;
    localparam logic [3:0] S_RMR   = 4'd11;
    localparam logic [3:0] S_RMW   = 4'd12;
    localparam logic [3:0] S_SURV  = 4'd13;
    localparam logic [3:0] S_FRD   = 4'd14;
    localparam logic [3:0] S_FCHK  = 4'd15;

    function automatic logic port_ok(input logic [PW-1:0] p);
        port_ok = (p != '0) && (int'(p) < NUM_PORTS);
    endfunction

    // control registers
    logic [3:0]                          state_reg, state_next;
    logic                                out_valid_reg, out_valid_next;
    logic [lpgt_pkg::PORT_SLOTS-1:0]     port_valid_reg;
    logic [lpgt_pkg::GROUP_IDS-1:0]      mem_valid_reg;
    logic                                port_rv_reg;
    logic                                mem_rv_reg;

    // item and walk registers
    logic                                func_reg, func_next;
    logic [PW-1:0]                       a_reg, a_next;
    logic [PW-1:0]                       b_reg, b_next;
    lpgt_pkg::port_ent_t                 ea_reg, ea_next;
    logic [PW-1:0]                       gid_reg, gid_next;
    logic [PW-1:0]                       gold_reg, gold_next;
    logic [PW-1:0]                       targ_reg, targ_next;
    logic                                two_reg, two_next;
    logic [CW-1:0]                       inc_reg, inc_next;
    logic                                merge_reg, merge_next;
    logic [IW-1:0]                       idx_reg, idx_next;
    logic                                pend_reg, pend_next;
    logic [PW-1:0]                       chk_reg, chk_next;
    logic [CW-1:0]                       cnt_reg, cnt_next;
    logic [PW-1:0]                       surv_reg, surv_next;

    // output registers
    logic                                in_group_reg, in_group_next;
    logic [PW-1:0]                       group_id_reg, group_id_next;
    logic                                det_req_reg, det_req_next;
    logic [PW-1:0]                       det_port_reg, det_port_next;

    // ram ports
    logic                                port_we, port_re;
    logic [PW-1:0]                       port_waddr, port_raddr;
    lpgt_pkg::port_ent_t                 port_wdata;
    logic [EW-1:0]                       port_rdata;
    logic                                mem_we, mem_re;
    logic [PW-1:0]                       mem_waddr, mem_raddr;
    logic [CW-1:0]                       mem_wdata;
    logic [CW-1:0]                       mem_rdata;

    lpgt_pkg::port_ent_t                 port_view;
    logic [CW-1:0]                       mem_view;
    logic [CW-1:0]                       mem_dec;
    logic                                in_acc;
    logic                                a_ok, b_ok;

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign a_ok     = port_ok(a_reg);
    assign b_ok     = port_ok(b_reg);

    // entries never written read as zero
    assign port_view = port_rv_reg ? lpgt_pkg::port_ent_t'(port_rdata) : '0;
    assign mem_view  = mem_rv_reg ? mem_rdata : '0;
    assign mem_dec   = (mem_view != '0) ? (mem_view - CW'(1)) : '0;

    lpgt_ram #(
        .WIDTH(EW),
        .DEPTH(lpgt_pkg::PORT_SLOTS)
    ) u_port_ram (
        .clk  (clk),
        .we   (port_we),
        .waddr(port_waddr),
        .wdata(port_wdata),
        .re   (port_re),
        .raddr(port_raddr),
        .rdata(port_rdata)
    );

    lpgt_ram #(
        .WIDTH(CW),
        .DEPTH(lpgt_pkg::GROUP_IDS)
    ) u_mem_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        func_next      = func_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        ea_next        = ea_reg;
        gid_next       = gid_reg;
        gold_next      = gold_reg;
        targ_next      = targ_reg;
        two_next       = two_reg;
        inc_next       = inc_reg;
        merge_next     = merge_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        chk_next       = chk_reg;
        cnt_next       = cnt_reg;
        surv_next      = surv_reg;
        in_group_next  = in_group_reg;
        group_id_next  = group_id_reg;
        det_req_next   = det_req_reg;
        det_port_next  = det_port_reg;
        port_we        = 1'b0;
        port_waddr     = '0;
        port_wdata     = '0;
        port_re        = 1'b0;
        port_raddr     = '0;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    func_next  = func;
                    a_next     = first_port;
                    b_next     = second_port;
                    surv_next  = '0;
                    merge_next = 1'b0;
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                port_re    = 1'b1;
                port_raddr = a_reg;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                port_re    = 1'b1;
                port_raddr = b_reg;
                ea_next    = port_view;
                state_next = S_DEC;
            end
            // port_view now holds the entry of the second port
            S_DEC:
            begin
                state_next = S_FRD;
                if (func_reg == lpgt_pkg::FUNC_LINK)
                begin
                    if (a_ok && b_ok)
                    begin
                        if (ea_reg.grouped && port_view.grouped)
                        begin
                            if (ea_reg.grp != port_view.grp)
                            begin
                                gid_next   = port_view.grp;
                                gold_next  = ea_reg.grp;
                                idx_next   = IW'(1);
                                pend_next  = 1'b0;
                                cnt_next   = '0;
                                state_next = S_MERGE;
                            end
                        end
                        else if (port_view.grouped)
                        begin
                            targ_next  = a_reg;
                            gid_next   = port_view.grp;
                            two_next   = 1'b0;
                            inc_next   = CW'(1);
                            state_next = S_PW1;
                        end
                        else if (ea_reg.grouped)
                        begin
                            targ_next  = b_reg;
                            gid_next   = ea_reg.grp;
                            two_next   = 1'b0;
                            inc_next   = CW'(1);
                            state_next = S_PW1;
                        end
                        else
                        begin
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            state_next = S_FREE;
                        end
                    end
                end
                else if ((func_reg == lpgt_pkg::FUNC_REMOVE) && a_ok && ea_reg.grouped)
                begin
                    gid_next   = ea_reg.grp;
                    state_next = S_RMR;
                end
            end
            // walk the ports, move members of the receiver group over
            S_MERGE:
            begin
                port_re    = !idx_reg[IW-1];
                port_raddr = idx_reg[PW-1:0];
                pend_next  = !idx_reg[IW-1];
                chk_next   = idx_reg[PW-1:0];
                if (!idx_reg[IW-1])
                begin
                    idx_next = idx_reg + IW'(1);
                end
                if (pend_reg && port_view.grouped && (port_view.grp == gold_reg))
                begin
                    port_we    = 1'b1;
                    port_waddr = chk_reg;
                    port_wdata = '{grouped: 1'b1, grp: gid_reg};
                    cnt_next   = cnt_reg + CW'(1);
                end
                if (idx_reg[IW-1] && !pend_reg)
                begin
                    inc_next   = cnt_reg;
                    merge_next = 1'b1;
                    state_next = S_MRD;
                end
            end
            // lowest group id with a zero member count
            S_FREE:
            begin
                mem_re    = !idx_reg[IW-1];
                mem_raddr = idx_reg[PW-1:0];
                pend_next = !idx_reg[IW-1];
                chk_next  = idx_reg[PW-1:0];
                if (!idx_reg[IW-1])
                begin
                    idx_next = idx_reg + IW'(1);
                end
                if (pend_reg && (mem_view == '0))
                begin
                    gid_next   = chk_reg;
                    targ_next  = a_reg;
                    two_next   = (a_reg != b_reg);
                    inc_next   = (a_reg != b_reg) ? CW'(2) : CW'(1);
                    state_next = S_PW1;
                end
                else if (idx_reg[IW-1] && !pend_reg)
                begin
                    state_next = S_FRD;
                end
            end
            S_PW1:
            begin
                port_we    = 1'b1;
                port_waddr = targ_reg;
                port_wdata = '{grouped: 1'b1, grp: gid_reg};
                state_next = two_reg ? S_PW2 : S_MRD;
            end
            S_PW2:
            begin
                port_we    = 1'b1;
                port_waddr = b_reg;
                port_wdata = '{grouped: 1'b1, grp: gid_reg};
                state_next = S_MRD;
            end
            S_MRD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = gid_reg;
                state_next = S_MWR;
            end
            S_MWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = gid_reg;
                mem_wdata  = mem_view + inc_reg;
                state_next = merge_reg ? S_MCLR : S_FRD;
            end
            S_MCLR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = gold_reg;
                mem_wdata  = '0;
                state_next = S_FRD;
            end
            // clear the removed port, fetch its group count
            S_RMR:
            begin
                port_we    = 1'b1;
                port_waddr = a_reg;
                port_wdata = '0;
                mem_re     = 1'b1;
                mem_raddr  = gid_reg;
                state_next = S_RMW;
            end
            S_RMW:
            begin
                mem_we    = 1'b1;
                mem_waddr = gid_reg;
                if (mem_dec == CW'(1))
                begin
                    mem_wdata  = '0;
                    idx_next   = IW'(1);
                    pend_next  = 1'b0;
                    state_next = S_SURV;
                end
                else
                begin
                    mem_wdata  = mem_dec;
                    state_next = S_FRD;
                end
            end
            // first remaining member of a dissolving group
            S_SURV:
            begin
                port_re    = !idx_reg[IW-1];
                port_raddr = idx_reg[PW-1:0];
                pend_next  = !idx_reg[IW-1];
                chk_next   = idx_reg[PW-1:0];
                if (!idx_reg[IW-1])
                begin
                    idx_next = idx_reg + IW'(1);
                end
                if (pend_reg && port_view.grouped && (port_view.grp == gid_reg))
                begin
                    port_we    = 1'b1;
                    port_waddr = chk_reg;
                    port_wdata = '0;
                    surv_next  = chk_reg;
                    state_next = S_FRD;
                end
                else if (idx_reg[IW-1] && !pend_reg)
                begin
                    state_next = S_FRD;
                end
            end
            S_FRD:
            begin
                port_re    = 1'b1;
                port_raddr = a_reg;
                state_next = S_FCHK;
            end
            // hand the result to the output register once it is free
            S_FCHK:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    in_group_next  = a_ok && port_view.grouped;
                    group_id_next  = (a_ok && port_view.grouped) ? port_view.grp : '0;
                    det_req_next   = (surv_reg != '0);
                    det_port_next  = surv_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            port_valid_reg <= '0;
            mem_valid_reg  <= '0;
            port_rv_reg    <= 1'b0;
            mem_rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (port_we)
            begin
                port_valid_reg[port_waddr] <= 1'b1;
            end
            if (mem_we)
            begin
                mem_valid_reg[mem_waddr] <= 1'b1;
            end
            if (port_re)
            begin
                port_rv_reg <= port_valid_reg[port_raddr];
            end
            if (mem_re)
            begin
                mem_rv_reg <= mem_valid_reg[mem_raddr];
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        ea_reg       <= ea_next;
        gid_reg      <= gid_next;
        gold_reg     <= gold_next;
        targ_reg     <= targ_next;
        two_reg      <= two_next;
        inc_reg      <= inc_next;
        merge_reg    <= merge_next;
        idx_reg      <= idx_next;
        pend_reg     <= pend_next;
        chk_reg      <= chk_next;
        cnt_reg      <= cnt_next;
        surv_reg     <= surv_next;
        in_group_reg <= in_group_next;
        group_id_reg <= group_id_next;
        det_req_reg  <= det_req_next;
        det_port_reg <= det_port_next;
    end

    assign out_valid      = out_valid_reg;
    assign in_group       = in_group_reg;
    assign group_id       = group_id_reg;
    assign detect_request = det_req_reg;
    assign detect_port    = det_port_reg;

    // checks on sequencer and result consistency
    `LPGT_ASSERT_NOW(a_port_rw_apart, port_we && port_re, port_waddr != port_raddr,
        "port ram read and write hit the same entry")
    `LPGT_ASSERT_NOW(a_detect_port_set, out_valid && detect_request, detect_port != '0,
        "detect request without a survivor port")
    `LPGT_ASSERT_NOW(a_detect_removed, out_valid && detect_request, !in_group,
        "dissolved group but first port still grouped")
    `LPGT_ASSERT_NOW(a_no_group_zero, out_valid && !in_group, group_id == '0,
        "ungrouped result with nonzero group id")
    `LPGT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "sequencer idle right after an accepted beat")

endmodule

// ----- design/lpgt_ram.sv -----
// generic single-write, single-read ram with registered read data
module lpgt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for the loop group table with a table predictor
module testbench;

    localparam int PORT_W     = lpgt_pkg::PORT_W;
    localparam int PORT_SLOTS = lpgt_pkg::PORT_SLOTS;
    localparam int GROUP_IDS  = lpgt_pkg::GROUP_IDS;
    localparam int CNT_W      = lpgt_pkg::CNT_W;

    localparam int NUM_PORTS   = 16;
    localparam int RAND_ITEMS  = 1800;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LO    = 800;
    localparam int QUIET_HI    = 1100;
    localparam int IDLE_PCT    = 33;
    localparam int DRAIN_WAIT  = 40;
    localparam int PRINT_MAX   = 40;

    // operation codes of the func field
    localparam logic FUNC_LINK   = lpgt_pkg::FUNC_LINK;
    localparam logic FUNC_REMOVE = lpgt_pkg::FUNC_REMOVE;

    typedef struct packed {
        logic              func;
        logic [PORT_W-1:0] first;
        logic [PORT_W-1:0] second;
    } table_op_t;

    typedef struct packed {
        logic              in_group;
        logic [PORT_W-1:0] group_id;
        logic              detect_request;
        logic [PORT_W-1:0] detect_port;
    } group_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              func = FUNC_LINK;
    logic [PORT_W-1:0] first_port = '0;
    logic [PORT_W-1:0] second_port = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              in_group;
    logic [PORT_W-1:0] group_id;
    logic              detect_request;
    logic [PORT_W-1:0] detect_port;

    logic              hold_off = 1'b0;
    int                accepted_cnt = 0;
    int                results_seen = 0;
    int                mismatch_cnt = 0;
    int                cycle_cnt = 0;

    table_op_t         pending_ops[$];
    group_result_t     expected_results[$];

    // predicted table state
    bit                shadow_grouped[PORT_SLOTS];
    bit [PORT_W-1:0]   shadow_group[PORT_SLOTS];
    bit [CNT_W-1:0]    shadow_members[GROUP_IDS];

    loop_port_group_table_top #(
        .NUM_PORTS(NUM_PORTS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .first_port     (first_port),
        .second_port    (second_port),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .in_group       (in_group),
        .group_id       (group_id),
        .detect_request (detect_request),
        .detect_port    (detect_port)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit port_valid(input logic [PORT_W-1:0] p);
        return p >= 1 && p < NUM_PORTS && p < PORT_SLOTS;
    endfunction

    function automatic void join_group(input int p, input logic [PORT_W-1:0] g);
        shadow_grouped[p] = 1'b1;
        shadow_group[p]   = g;
        shadow_members[g] = shadow_members[g] + 1'b1;
    endfunction

    // apply one operation to the shadow table and return the result it yields
    function automatic group_result_t table_update(input table_op_t op);
        group_result_t   r;
        bit              rx_in, tx_in, found;
        logic [PORT_W-1:0] gr, gt, survivor, g;
        int              rx, tx;
        r        = '0;
        survivor = '0;
        rx       = int'(op.first);
        tx       = int'(op.second);
        if (op.func == FUNC_LINK)
        begin
            if (port_valid(op.first) && port_valid(op.second))
            begin
                rx_in = shadow_grouped[rx];
                tx_in = shadow_grouped[tx];
                if (tx_in && rx_in)
                begin
                    gr = shadow_group[rx];
                    gt = shadow_group[tx];
                    // merge receiver group into sender group
                    if (gr != gt)
                    begin
                        for (int p = 1; p < PORT_SLOTS; p++)
                        begin
                            if (shadow_grouped[p] && shadow_group[p] == gr)
                                join_group(p, gt);
                        end
                        shadow_members[gr] = '0;
                    end
                end
                else if (tx_in)
                begin
                    join_group(rx, shadow_group[tx]);
                end
                else if (rx_in)
                begin
                    join_group(tx, shadow_group[rx]);
                end
                else
                begin
                    // new group from the lowest free id
                    found = 1'b0;
                    g     = '0;
                    for (int i = 0; i < GROUP_IDS; i++)
                    begin
                        if (!found && shadow_members[i] == 0)
                        begin
                            found = 1'b1;
                            g     = PORT_W'(i);
                        end
                    end
                    if (found)
                    begin
                        join_group(rx, g);
                        if (tx != rx)
                            join_group(tx, g);
                    end
                end
            end
        end
        else
        begin
            if (port_valid(op.first) && shadow_grouped[rx])
            begin
                g = shadow_group[rx];
                shadow_grouped[rx] = 1'b0;
                shadow_group[rx]   = '0;
                if (shadow_members[g] != 0)
                    shadow_members[g] = shadow_members[g] - 1'b1;
                // one member left: dissolve and hand back the survivor
                if (shadow_members[g] == 1)
                begin
                    found = 1'b0;
                    for (int p = 1; p < PORT_SLOTS; p++)
                    begin
                        if (!found && shadow_grouped[p] && shadow_group[p] == g)
                        begin
                            found             = 1'b1;
                            survivor          = PORT_W'(p);
                            shadow_grouped[p] = 1'b0;
                            shadow_group[p]   = '0;
                        end
                    end
                    shadow_members[g] = '0;
                end
            end
        end
        if (port_valid(op.first) && shadow_grouped[rx])
        begin
            r.in_group = 1'b1;
            r.group_id = shadow_group[rx];
        end
        r.detect_request = survivor != 0;
        r.detect_port    = survivor;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_MAX)
            $display("mismatch at result %0d: %s got %0d want %0d",
                     results_seen, what, got, want);
    endtask

    task automatic queue_op(input logic f, input int a, input int b);
        table_op_t op;
        op.func   = f;
        op.first  = PORT_W'(a);
        op.second = PORT_W'(b);
        pending_ops.push_back(op);
    endtask

    function automatic bit sender_idles();
        if (accepted_cnt >= QUIET_LO && accepted_cnt < QUIET_HI)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    function automatic bit receiver_idles();
        if (results_seen >= QUIET_LO && results_seen < QUIET_HI)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // input driver: offer the next pending op once the current beat is taken
    always @(posedge clk)
    begin : drive_ops
        table_op_t nxt;
        table_op_t taken;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                taken.func   = func;
                taken.first  = first_port;
                taken.second = second_port;
                expected_results.push_back(table_update(taken));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (pending_ops.size() != 0 && !sender_idles())
            begin
                nxt = pending_ops.pop_front();
                in_valid    <= 1'b1;
                func        <= nxt.func;
                first_port  <= nxt.first;
                second_port <= nxt.second;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output monitor: check each result beat against the oldest prediction
    always @(posedge clk)
    begin : check_results
        group_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("beat with nothing expected", 1, 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (in_group !== want.in_group)
                        report_mismatch("in_group", int'(in_group), int'(want.in_group));
                    if (group_id !== want.group_id)
                        report_mismatch("group_id", int'(group_id), int'(want.group_id));
                    if (detect_request !== want.detect_request)
                        report_mismatch("detect_request", int'(detect_request),
                                        int'(want.detect_request));
                    if (detect_port !== want.detect_port)
                        report_mismatch("detect_port", int'(detect_port),
                                        int'(want.detect_port));
                end
                results_seen <= results_seen + 1;
            end
            out_ready <= !hold_off && !receiver_idles();
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial
    begin
        while (results_seen < HOLD_AT)
            @(posedge clk);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial
    begin : run_test
        int total;
        int k;
        int a;
        int b;
        int hi;

        // invalid ports and removal of ungrouped ports
        queue_op(FUNC_LINK, 0, 3);
        queue_op(FUNC_LINK, 3, 0);
        queue_op(FUNC_REMOVE, 0, 15);
        queue_op(FUNC_REMOVE, 5, 0);
        // new group, single-port group, joins from both sides, merge, same group
        queue_op(FUNC_LINK, 1, 2);
        queue_op(FUNC_LINK, 3, 3);
        queue_op(FUNC_LINK, 4, 1);
        queue_op(FUNC_LINK, 2, 5);
        queue_op(FUNC_LINK, 3, 1);
        queue_op(FUNC_LINK, 1, 2);
        // freed id reused, second merge
        queue_op(FUNC_LINK, 6, 7);
        queue_op(FUNC_LINK, 8, 9);
        queue_op(FUNC_LINK, 6, 8);
        // shrink to one member: dissolve with survivor
        queue_op(FUNC_REMOVE, 6, 9);
        queue_op(FUNC_REMOVE, 7, 0);
        queue_op(FUNC_REMOVE, 8, 15);
        queue_op(FUNC_REMOVE, 9, 0);
        // single-port group left empty
        queue_op(FUNC_LINK, 10, 10);
        queue_op(FUNC_REMOVE, 10, 10);
        // highest port
        queue_op(FUNC_LINK, 15, 14);
        queue_op(FUNC_REMOVE, 15, 0);
        queue_op(FUNC_LINK, 15, 15);
        queue_op(FUNC_LINK, 0, 15);
        queue_op(FUNC_REMOVE, 15, 15);

        // random traffic: mostly valid ports, a narrow pool to force merges
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 12)
            begin
                queue_op(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                         $urandom_range(0, 15));
            end
            else
            begin
                hi = ($urandom_range(0, 3) == 0) ? 15 : 6;
                a  = $urandom_range(1, hi);
                b  = $urandom_range(1, hi);
                if (k < 62)
                    queue_op(FUNC_LINK, a, b);
                else
                    queue_op(FUNC_REMOVE, a, $urandom_range(0, 15));
            end
        end
        total = pending_ops.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt < total)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
